// ===== hw/rtl/rto_pkg.sv =====
// Shared types, constants and microcode tables for the ray/triangle occlusion block.
package rto_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FIELD_W     = 32;
	localparam int EDGE_W      = COORD_WIDTH + 1;
	localparam int MID_W       = 2 * EDGE_W + 1;
	localparam int OP_W        = EDGE_W + 1;
	localparam int PROD_W      = 2 * OP_W;
	localparam int ACC_W       = MID_W + EDGE_W + 20;
	localparam int EPS_W       = 32;
	localparam int TMIN_W      = 16;
	localparam int TFRAC       = 16;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 32;
	localparam int DET_LIMBS   = 3;

	localparam logic [CFG_IDX_W-1:0] REG_DET_EPSILON = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_T_MINIMUM   = 1'd1;
	localparam logic [EPS_W-1:0]     DET_EPS_RESET   = 32'd1;

	localparam logic FUNC_RAY = 1'b0;
	localparam logic FUNC_TRI = 1'b1;

	localparam logic [2:0] GRP_H    = 3'd0;
	localparam logic [2:0] GRP_Q    = 3'd1;
	localparam logic [2:0] GRP_DET  = 3'd2;
	localparam logic [2:0] GRP_U    = 3'd3;
	localparam logic [2:0] GRP_V    = 3'd4;
	localparam logic [2:0] GRP_T    = 3'd5;
	localparam logic [2:0] LAST_SUB = 3'd5;

	typedef struct packed {
		logic                      func;
		logic signed [FIELD_W-1:0] a_x;
		logic signed [FIELD_W-1:0] a_y;
		logic signed [FIELD_W-1:0] a_z;
		logic signed [FIELD_W-1:0] b_x;
		logic signed [FIELD_W-1:0] b_y;
		logic signed [FIELD_W-1:0] b_z;
		logic signed [FIELD_W-1:0] c_x;
		logic signed [FIELD_W-1:0] c_y;
		logic signed [FIELD_W-1:0] c_z;
		logic                      skip_triangle;
		logic                      last;
	} item_t;

	typedef struct packed {
		logic visible;
	} result_t;

	typedef enum logic [2:0] {A_DIR, A_E1, A_E2, A_S, A_TMIN} asel_t;
	typedef enum logic [2:0] {B_E1, B_E2, B_H, B_Q, B_DET} bsel_t;
	typedef enum logic [1:0] {ACC_FIRST, ACC_ADD, ACC_SUB, ACC_LOAD_T} accop_t;
	typedef enum logic [2:0] {D_NONE, D_H, D_Q, D_DET, D_U, D_V, D_T} dest_t;

	typedef struct packed {
		logic       valid;
		asel_t      asel;
		logic [1:0] aidx;
		bsel_t      bsel;
		logic [1:0] bidx;
		logic [1:0] limb;
		accop_t     op;
		dest_t      dest;
		logic [1:0] didx;
	} mcmd_t;

	typedef struct packed {
		mcmd_t mul;
		logic  ld_ray;
		logic  ld_tri;
		logic  norm;
		logic  check;
		logic  update;
		logic  emit;
	} cmd_t;

	typedef struct packed {
		logic still_visible;
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_PROD, S_DRAIN, S_NORM, S_CHECK, S_TMUL, S_DRAIN2, S_FINAL, S_OUT
	} state_t;

	localparam mcmd_t MCMD_NONE = '{valid: 1'b0, asel: A_DIR, aidx: 2'd0, bsel: B_E1,
		bidx: 2'd0, limb: 2'd0, op: ACC_FIRST, dest: D_NONE, didx: 2'd0};

	// Next component index modulo three.
	function automatic logic [1:0] next3(input logic [1:0] i);
		logic [1:0] r;
		case (i)
			2'd0: r = 2'd1;
			2'd1: r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	// Microcode for the cross and dot products: six groups of six partial products.
	function automatic mcmd_t prod_cmd(input logic [2:0] grp, input logic [2:0] sub);
		mcmd_t      m;
		logic [1:0] c;
		logic [1:0] j;
		logic [1:0] k;
		logic       second;
		m      = MCMD_NONE;
		c      = sub[2:1];
		second = sub[0];
		j      = next3(c);
		k      = next3(j);
		m.valid = 1'b1;
		if (grp == GRP_H || grp == GRP_Q) begin
			m.asel = (grp == GRP_H) ? A_DIR : A_S;
			m.bsel = (grp == GRP_H) ? B_E2 : B_E1;
			m.limb = 2'd0;
			m.didx = c;
			if (!second) begin
				m.aidx = j;
				m.bidx = k;
				m.op   = ACC_FIRST;
			end else begin
				m.aidx = k;
				m.bidx = j;
				m.op   = ACC_SUB;
				m.dest = (grp == GRP_H) ? D_H : D_Q;
			end
		end else begin
			m.aidx = c;
			m.bidx = c;
			m.limb = {1'b0, second};
			m.op   = (sub == 3'd0) ? ACC_FIRST : ACC_ADD;
			case (grp)
				GRP_DET: begin
					m.asel = A_E1;
					m.bsel = B_H;
					m.dest = D_DET;
				end
				GRP_U: begin
					m.asel = A_S;
					m.bsel = B_H;
					m.dest = D_U;
				end
				GRP_V: begin
					m.asel = A_DIR;
					m.bsel = B_Q;
					m.dest = D_V;
				end
				default: begin
					m.asel = A_E2;
					m.bsel = B_Q;
					m.dest = D_T;
				end
			endcase
			if (sub != LAST_SUB) m.dest = D_NONE;
		end
		return m;
	endfunction

	// Loads the accumulator with T scaled to the Q16 of t_minimum.
	function automatic mcmd_t load_t_cmd();
		mcmd_t m;
		m       = MCMD_NONE;
		m.valid = 1'b1;
		m.op    = ACC_LOAD_T;
		return m;
	endfunction

	// Subtracts t_minimum times one limb of the normalized determinant.
	function automatic mcmd_t tmul_cmd(input logic [1:0] limb);
		mcmd_t m;
		m       = MCMD_NONE;
		m.valid = 1'b1;
		m.asel  = A_TMIN;
		m.bsel  = B_DET;
		m.limb  = limb;
		m.op    = ACC_SUB;
		return m;
	endfunction

endpackage

// ===== hw/rtl/rto_if.sv =====
// Handshake channel interfaces for items, results and configuration writes.
interface rto_item_if;
	logic          valid;
	logic          ready;
	rto_pkg::item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rto_result_if;
	logic             valid;
	logic             ready;
	rto_pkg::result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rto_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [rto_pkg::CFG_IDX_W-1:0]      index;
	logic [rto_pkg::CFG_DATA_W-1:0]     data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/rto_datapath.sv =====
// Datapath: ray and edge registers, shared multiplier, wide accumulator and hit test.
module rto_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rto_pkg::cmd_t                  cmd,
	input  rto_pkg::item_t                 item_data,
	input  logic                           cfg_we,
	input  logic [rto_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rto_pkg::CFG_DATA_W-1:0] cfg_data,
	output rto_pkg::status_t               status,
	output rto_pkg::result_t               result_data
);
	localparam int CW = rto_pkg::COORD_WIDTH;
	localparam int EW = rto_pkg::EDGE_W;
	localparam int MW = rto_pkg::MID_W;
	localparam int OW = rto_pkg::OP_W;
	localparam int PW = rto_pkg::PROD_W;
	localparam int AW = rto_pkg::ACC_W;

	logic signed [CW-1:0] org_q [3];
	logic signed [CW-1:0] dir_q [3];
	logic signed [EW-1:0] e1_q [3];
	logic signed [EW-1:0] e2_q [3];
	logic signed [EW-1:0] s_q [3];
	logic signed [MW-1:0] h_q [3];
	logic signed [MW-1:0] q_q [3];
	logic signed [AW-1:0] det_q, u_q, v_q, t_q, acc_q, uv_q, acc_nx, term;
	logic signed [PW-1:0] prod_s1;
	rto_pkg::mcmd_t       mcmd_s1;
	logic [rto_pkg::EPS_W-1:0]  eps_q;
	logic [rto_pkg::TMIN_W-1:0] tmin_q;
	logic                 still_q, ok_q, vis_q;
	logic signed [CW-1:0] v0 [3];
	logic signed [CW-1:0] v1 [3];
	logic signed [CW-1:0] v2 [3];
	logic signed [OW-1:0] op_a, op_b;
	logic signed [MW-1:0] mid_sel;
	logic                 hit;

	assign v0[0] = item_data.a_x[CW-1:0];
	assign v0[1] = item_data.a_y[CW-1:0];
	assign v0[2] = item_data.a_z[CW-1:0];
	assign v1[0] = item_data.b_x[CW-1:0];
	assign v1[1] = item_data.b_y[CW-1:0];
	assign v1[2] = item_data.b_z[CW-1:0];
	assign v2[0] = item_data.c_x[CW-1:0];
	assign v2[1] = item_data.c_y[CW-1:0];
	assign v2[2] = item_data.c_z[CW-1:0];

	// Ray state is architectural and starts from zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				org_q[i] <= '0;
				dir_q[i] <= '0;
			end
		end else if (cmd.ld_ray) begin
			for (int i = 0; i < 3; i++) begin
				org_q[i] <= v0[i];
				dir_q[i] <= v1[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_tri) begin
			for (int i = 0; i < 3; i++) begin
				e1_q[i] <= EW'(v1[i]) - EW'(v0[i]);
				e2_q[i] <= EW'(v2[i]) - EW'(v0[i]);
				s_q[i]  <= EW'(org_q[i]) - EW'(v0[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q  <= rto_pkg::DET_EPS_RESET;
			tmin_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rto_pkg::REG_DET_EPSILON: eps_q <= cfg_data[rto_pkg::EPS_W-1:0];
				rto_pkg::REG_T_MINIMUM: tmin_q <= cfg_data[rto_pkg::TMIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		case (cmd.mul.asel)
			rto_pkg::A_DIR: op_a = OW'(dir_q[cmd.mul.aidx]);
			rto_pkg::A_E1: op_a = OW'(e1_q[cmd.mul.aidx]);
			rto_pkg::A_E2: op_a = OW'(e2_q[cmd.mul.aidx]);
			rto_pkg::A_S: op_a = OW'(s_q[cmd.mul.aidx]);
			default: op_a = $signed(OW'(tmin_q));
		endcase
	end

	always_comb begin
		mid_sel = (cmd.mul.bsel == rto_pkg::B_H) ? h_q[cmd.mul.bidx] : q_q[cmd.mul.bidx];
		case (cmd.mul.bsel)
			rto_pkg::B_E1: op_b = OW'(e1_q[cmd.mul.bidx]);
			rto_pkg::B_E2: op_b = OW'(e2_q[cmd.mul.bidx]);
			rto_pkg::B_H, rto_pkg::B_Q: begin
				// Wide values split into an unsigned low limb and a signed high part.
				if (cmd.mul.limb == 2'd0) op_b = $signed({1'b0, mid_sel[EW-1:0]});
				else op_b = mid_sel[MW-1:EW];
			end
			default: begin
				case (cmd.mul.limb)
					2'd0: op_b = $signed({1'b0, det_q[EW-1:0]});
					2'd1: op_b = $signed({1'b0, det_q[2*EW-1:EW]});
					default: op_b = $signed({1'b0, det_q[3*EW-1:2*EW]});
				endcase
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mcmd_s1 <= rto_pkg::MCMD_NONE;
		else mcmd_s1 <= cmd.mul;
	end

	always_comb begin
		case (mcmd_s1.limb)
			2'd0: term = AW'(prod_s1);
			2'd1: term = AW'(prod_s1) <<< EW;
			default: term = AW'(prod_s1) <<< (2 * EW);
		endcase
		case (mcmd_s1.op)
			rto_pkg::ACC_FIRST: acc_nx = term;
			rto_pkg::ACC_ADD: acc_nx = acc_q + term;
			rto_pkg::ACC_SUB: acc_nx = acc_q - term;
			default: acc_nx = t_q <<< rto_pkg::TFRAC;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mcmd_s1.valid) acc_q <= acc_nx;
	end

	always_ff @(posedge clk) begin
		if (mcmd_s1.valid) begin
			case (mcmd_s1.dest)
				rto_pkg::D_H: h_q[mcmd_s1.didx] <= acc_nx[MW-1:0];
				rto_pkg::D_Q: q_q[mcmd_s1.didx] <= acc_nx[MW-1:0];
				default: ;
			endcase
		end
	end

	// Triple products; a negative determinant flips all four so the tests need no sign cases.
	always_ff @(posedge clk) begin
		if (mcmd_s1.valid) begin
			case (mcmd_s1.dest)
				rto_pkg::D_DET: det_q <= acc_nx;
				rto_pkg::D_U: u_q <= acc_nx;
				rto_pkg::D_V: v_q <= acc_nx;
				rto_pkg::D_T: t_q <= acc_nx;
				default: ;
			endcase
		end else if (cmd.norm && det_q[AW-1]) begin
			det_q <= -det_q;
			u_q   <= -u_q;
			v_q   <= -v_q;
			t_q   <= -t_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			ok_q <= !(det_q < $signed(AW'(eps_q))) && !u_q[AW-1] && !(det_q < u_q)
				&& !v_q[AW-1];
			uv_q <= u_q + v_q;
		end
	end

	// The accumulator holds T*2^16 - t_minimum*det at this point.
	assign hit = ok_q && !(det_q < uv_q) && (acc_q > $signed(AW'(0)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			still_q <= 1'b1;
		end else if (cmd.ld_ray || cmd.emit) begin
			still_q <= 1'b1;
		end else if (cmd.update && hit) begin
			still_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) vis_q <= still_q;
	end

	assign status.still_visible = still_q;
	assign result_data.visible  = vis_q;

endmodule

// ===== hw/rtl/rto_controller.sv =====
// Controller: sequences the product microcode, the normalize and check steps and the result.
module rto_controller (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_func,
	input  logic             item_skip,
	input  logic             item_last,
	output logic             item_ready,
	output logic             res_valid,
	input  logic             res_ready,
	input  rto_pkg::status_t status,
	output rto_pkg::cmd_t    cmd
);
	rto_pkg::state_t state_q, state_nx;
	logic [2:0] grp_q, sub_q;
	logic [1:0] tcnt_q;
	logic       last_q, out_valid_q;
	logic       accept, test_tri, prod_done;

	assign item_ready = (state_q == rto_pkg::S_IDLE);
	assign accept     = item_valid && item_ready;
	assign test_tri   = (item_func == rto_pkg::FUNC_TRI) && !item_skip
		&& status.still_visible;
	assign prod_done  = (grp_q == rto_pkg::GRP_T) && (sub_q == rto_pkg::LAST_SUB);

	always_comb begin
		state_nx = state_q;
		case (state_q)
			rto_pkg::S_IDLE: begin
				if (item_valid) begin
					if (test_tri) state_nx = rto_pkg::S_PROD;
					else if (item_last) state_nx = rto_pkg::S_OUT;
				end
			end
			rto_pkg::S_PROD: if (prod_done) state_nx = rto_pkg::S_DRAIN;
			rto_pkg::S_DRAIN: state_nx = rto_pkg::S_NORM;
			rto_pkg::S_NORM: state_nx = rto_pkg::S_CHECK;
			rto_pkg::S_CHECK: state_nx = rto_pkg::S_TMUL;
			rto_pkg::S_TMUL: begin
				if (tcnt_q == 2'(rto_pkg::DET_LIMBS - 1)) state_nx = rto_pkg::S_DRAIN2;
			end
			rto_pkg::S_DRAIN2: state_nx = rto_pkg::S_FINAL;
			rto_pkg::S_FINAL: state_nx = last_q ? rto_pkg::S_OUT : rto_pkg::S_IDLE;
			rto_pkg::S_OUT: if (!out_valid_q || res_ready) state_nx = rto_pkg::S_IDLE;
			default: state_nx = rto_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd     = '0;
		cmd.mul = rto_pkg::MCMD_NONE;
		case (state_q)
			rto_pkg::S_IDLE: begin
				cmd.ld_ray = item_valid && (item_func == rto_pkg::FUNC_RAY);
				cmd.ld_tri = item_valid && test_tri;
			end
			rto_pkg::S_PROD: cmd.mul = rto_pkg::prod_cmd(grp_q, sub_q);
			rto_pkg::S_NORM: cmd.norm = 1'b1;
			rto_pkg::S_CHECK: begin
				cmd.check = 1'b1;
				cmd.mul   = rto_pkg::load_t_cmd();
			end
			rto_pkg::S_TMUL: cmd.mul = rto_pkg::tmul_cmd(tcnt_q);
			rto_pkg::S_FINAL: cmd.update = 1'b1;
			rto_pkg::S_OUT: cmd.emit = !out_valid_q || res_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rto_pkg::S_IDLE;
			grp_q       <= '0;
			sub_q       <= '0;
			tcnt_q      <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				last_q <= item_last;
				grp_q  <= '0;
				sub_q  <= '0;
			end else if (state_q == rto_pkg::S_PROD) begin
				if (sub_q == rto_pkg::LAST_SUB) begin
					sub_q <= '0;
					grp_q <= grp_q + 3'd1;
				end else begin
					sub_q <= sub_q + 3'd1;
				end
			end
			if (state_q == rto_pkg::S_CHECK) tcnt_q <= '0;
			else if (state_q == rto_pkg::S_TMUL) tcnt_q <= tcnt_q + 2'd1;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (res_ready) out_valid_q <= 1'b0;
		end
	end

	assign res_valid = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || res_ready))
		else $error("result overwritten before transfer");

	a_counters: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rto_pkg::S_PROD) |-> (sub_q <= rto_pkg::LAST_SUB)
		&& (grp_q <= rto_pkg::GRP_T))
		else $error("microcode counter out of range");

	a_final_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rto_pkg::S_FINAL) |-> ($past(state_q) == rto_pkg::S_DRAIN2))
		else $error("hit decision without completed t test");

	a_ld_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ld_ray && cmd.ld_tri) && !(cmd.mul.valid && cmd.emit))
		else $error("conflicting datapath commands");

endmodule

// ===== hw/rtl/ray_triangle_occlusion_test.sv =====
// Top level of the ray/triangle any-hit occlusion block.
//
//  channel | direction | payload                          | transfer when
//  item    | in        | func, a/b/c xyz, skip, last      | item.valid && item.ready
//  result  | out       | visible                          | result.valid && result.ready
//  cfg     | in        | index (0 det_epsilon, 1 t_min)   | cfg.valid (ready held high)
//
// A ray item, a skipped triangle or a triangle after a hit is accepted in idle with no product sequence.
// A tested triangle runs 39 partial products through the one
// shared 34x34 multiplier plus drain, normalize, check and decision steps.
// An item with last then passes through S_OUT to move the result into the output register,
// and holds there while the previous result has not yet been transferred.
// The next item is taken while an earlier result still waits in that register.
// Reset clears the ray to zero, sets the visible flag and loads the register defaults.
module ray_triangle_occlusion_test (
	input logic           clk,
	input logic           arst_n,
	rto_item_if.sink      item,
	rto_result_if.source  result,
	rto_cfg_if.sink       cfg
);
	rto_pkg::cmd_t    cmd;
	rto_pkg::status_t status;

	assign cfg.ready = 1'b1;

	rto_controller u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_func  (item.data.func),
		.item_skip  (item.data.skip_triangle),
		.item_last  (item.data.last),
		.item_ready (item.ready),
		.res_valid  (result.valid),
		.res_ready  (result.ready),
		.status     (status),
		.cmd        (cmd)
	);

	rto_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.item_data   (item.data),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.status      (status),
		.result_data (result.data)
	);

endmodule
